### src/kdpc_pkg.sv
// Shared types and constants for the key debounce / press classifier.
// Request payloads, event codes, register indexes and lane interface structs.
// No dependencies.
package kdpc_pkg;

    localparam int MAX_KEYS  = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int EV_W      = 3;

    // Event codes
    localparam logic [EV_W-1:0] EV_DOWN         = 3'd0;
    localparam logic [EV_W-1:0] EV_UP           = 3'd1;
    localparam logic [EV_W-1:0] EV_SHORT        = 3'd2;
    localparam logic [EV_W-1:0] EV_LONG         = 3'd3;
    localparam logic [EV_W-1:0] EV_HOLD         = 3'd4;
    localparam logic [EV_W-1:0] EV_LONG_RELEASE = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LP_K0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LP_K1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LP_K2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LP_K3    = 3'd6;

    localparam logic [15:0] DEBOUNCE_RST = 16'd20;
    localparam logic [15:0] LONG_DEFAULT = 16'd1000;

    typedef struct packed {
        logic [3:0]  raw_levels;
        logic [15:0] tick_ms;
    } t_in;

    typedef struct packed {
        logic [1:0]      key_id;
        logic [EV_W-1:0] key_event;
        logic [3:0]      pressed_mask;
        logic            last_of_tick;
    } t_out;

    // Per-lane control for one tick
    typedef struct packed {
        logic        step;
        logic        prime;
        logic        raw;
        logic        en;
        logic        act;
        logic [15:0] period;
        logic [15:0] deb;
        logic [15:0] lp;
    } t_lane_ctl;

    // What one lane found in one tick: up to two events
    typedef struct packed {
        logic [1:0]           ev_v;
        logic [1:0][EV_W-1:0] ev_code;
        logic                 pressed;
    } t_lane_res;

endpackage

### src/kdpc_lane.sv
// One key lane: debounce, stable level, held time and long flag of one key.
// Produces up to two events per tick from the lane control struct.
// Depends on kdpc_pkg.
module kdpc_lane
    import kdpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    output t_lane_res o_res
);

    logic        r_stable, n_stable;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_held, n_held;
    logic        r_lr, n_lr;

    logic        now, diff, flip, hit;
    logic [16:0] acc_sum, held_sum;
    logic [15:0] acc_sat, held_sat, held_base, lp_eff;
    logic        lr_base;

    always_comb begin
        now       = (i_ctl.raw == i_ctl.act);
        diff      = (now != r_stable);
        acc_sum   = {1'b0, r_acc} + {1'b0, i_ctl.period};
        acc_sat   = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
        flip      = diff && (acc_sat >= i_ctl.deb);
        n_stable  = flip ? now : r_stable;
        // a fresh press restarts held time and the long flag
        held_base = (flip && now) ? 16'd0 : r_held;
        lr_base   = (flip && now) ? 1'b0 : r_lr;
        held_sum  = {1'b0, held_base} + {1'b0, i_ctl.period};
        held_sat  = held_sum[16] ? 16'hFFFF : held_sum[15:0];
        lp_eff    = (i_ctl.lp == 16'd0) ? LONG_DEFAULT : i_ctl.lp;
        hit       = n_stable && (held_sat >= lp_eff);

        n_acc  = (diff && !flip) ? acc_sat : 16'd0;
        n_held = n_stable ? held_sat : held_base;
        n_lr   = lr_base | hit;

        o_res.ev_v    = 2'b00;
        o_res.ev_code = {EV_DOWN, EV_DOWN};
        o_res.pressed = n_stable;
        if (i_ctl.step && i_ctl.en) begin
            if (flip && now) begin
                o_res.ev_v[0]    = 1'b1;
                o_res.ev_code[0] = EV_DOWN;
                o_res.ev_v[1]    = hit;
                o_res.ev_code[1] = EV_LONG;
            end else if (flip) begin
                o_res.ev_v       = 2'b11;
                o_res.ev_code[0] = EV_UP;
                o_res.ev_code[1] = r_lr ? EV_LONG_RELEASE : EV_SHORT;
            end else if (hit) begin
                o_res.ev_v[0]    = 1'b1;
                o_res.ev_code[0] = lr_base ? EV_HOLD : EV_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_acc    <= '0;
            r_held   <= '0;
            r_lr     <= 1'b0;
        end else if (i_ctl.prime) begin
            r_stable <= now;
            r_acc    <= '0;
            r_held   <= '0;
            r_lr     <= 1'b0;
        end else if (i_ctl.step && i_ctl.en) begin
            r_stable <= n_stable;
            r_acc    <= n_acc;
            r_held   <= n_held;
            r_lr     <= n_lr;
        end
    end

endmodule

### src/kdpc_merge.sv
// Merge stage: holds the event slots of one tick and drains them in key order,
// one per cycle while i_stall does not hold the output register, into the output register. Depends on kdpc_pkg.
module kdpc_merge
    import kdpc_pkg::*;
#(
    parameter int NUM_KEYS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [NUM_KEYS-1:0][1:0]          i_ev_v,
    input  logic [NUM_KEYS-1:0][1:0][EV_W-1:0] i_ev_code,
    input  logic [3:0]                        i_mask,
    output logic                              o_busy,
    output logic                              o_valid,
    input  logic                              i_stall,
    output t_out                              o_data
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [NUM_KEYS-1:0][1:0]           r_v, n_v;
    logic [NUM_KEYS-1:0][1:0][EV_W-1:0] r_code;
    logic [3:0]                         r_mask;
    logic                               r_out_v;
    t_out                               r_out;

    logic          any, pop, last_pop;
    logic [KW-1:0] pick_k;
    logic          pick_j;

    // Lowest occupied slot goes first
    always_comb begin
        pick_k = '0;
        pick_j = 1'b0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            for (int j = 1; j >= 0; j--) begin
                if (r_v[k][j]) begin
                    pick_k = KW'(k);
                    pick_j = j[0];
                end
            end
        end
        any = |r_v;
        pop = any && (!r_out_v || !i_stall);
        n_v = r_v;
        if (pop) begin
            n_v[pick_k][pick_j] = 1'b0;
        end
        last_pop = pop && (n_v == '0);
    end

    assign o_busy  = any && !last_pop;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_v <= i_load ? i_ev_v : n_v;
            if (!r_out_v || !i_stall) begin
                r_out_v <= any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= i_ev_code;
            r_mask <= i_mask;
        end
        if (pop) begin
            r_out.key_id       <= 2'(pick_k);
            r_out.key_event    <= r_code[pick_k][pick_j];
            r_out.pressed_mask <= r_mask;
            r_out.last_of_tick <= (n_v == '0);
        end
    end

endmodule

### src/key_debounce_press_classifier.sv
// Top level of the key debounce / press classifier: configuration registers,
// priming, the per-key lanes and the merge stage. Depends on kdpc_pkg,
// kdpc_lane and kdpc_merge.
//
//  channel   dir  handshake                      payload
//  in        in   i_in_valid  / o_in_stall       i_in_data  (t_in)
//  out       out  o_out_valid / i_out_stall      o_out_data (t_out)
//  cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// All lanes evaluate a request in the cycle it is accepted; its events
// (at most two per key) are loaded into the merge slots and then pass one
// per cycle, while the output is not stalled, through the output register.
// A request may enter every cycle while the merge stage is empty or about to
// drain its last event, so the input rate is set by the event count.
// Reset is synchronous; no clearing pass. Output stall holds the output
// register and backs up into o_in_stall while the merge stage holds events.
module key_debounce_press_classifier
    import kdpc_pkg::*;
#(
    parameter int NUM_KEYS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [3:0]                     r_key_en, r_act_hi;
    logic [15:0]                    r_deb;
    logic [MAX_KEYS-1:0][15:0]      r_lp;
    logic                           r_primed;

    logic                               accept, busy, prime, step;
    logic [NUM_KEYS-1:0][1:0]           ev_v;
    logic [NUM_KEYS-1:0][1:0][EV_W-1:0] ev_code;
    logic [3:0]                         mask;
    t_lane_ctl                          ctl [NUM_KEYS];
    t_lane_res                          res [NUM_KEYS];

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;
    assign prime      = accept && (i_in_data.tick_ms != 16'd0) && !r_primed;
    assign step       = accept && (i_in_data.tick_ms != 16'd0) && r_primed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_en <= '0;
            r_act_hi <= '0;
            r_deb    <= DEBOUNCE_RST;
            r_lp     <= {MAX_KEYS{LONG_DEFAULT}};
            r_primed <= 1'b0;
        end else begin
            if (prime) begin
                r_primed <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY_EN:   r_key_en <= i_cfg_data[3:0];
                    REG_ACT_HIGH: r_act_hi <= i_cfg_data[3:0];
                    REG_DEBOUNCE: r_deb    <= i_cfg_data;
                    REG_LP_K0:    r_lp[0]  <= i_cfg_data;
                    REG_LP_K1:    r_lp[1]  <= i_cfg_data;
                    REG_LP_K2:    r_lp[2]  <= i_cfg_data;
                    REG_LP_K3:    r_lp[3]  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        mask = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            mask[k] = r_key_en[k] && res[k].pressed;
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        assign ctl[k] = '{
            step:   step,
            prime:  prime,
            raw:    i_in_data.raw_levels[k],
            en:     r_key_en[k],
            act:    r_act_hi[k],
            period: i_in_data.tick_ms,
            deb:    r_deb,
            lp:     r_lp[k]
        };
        assign ev_v[k]    = res[k].ev_v;
        assign ev_code[k] = res[k].ev_code;

        kdpc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[k]),
            .o_res   (res[k])
        );
    end

    kdpc_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (step),
        .i_ev_v    (ev_v),
        .i_ev_code (ev_code),
        .i_mask    (mask),
        .o_busy    (busy),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_data    (o_out_data)
    );

    // No event before the first priming request
    a_no_event_unprimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> !o_out_valid)
        else $error("event before priming");

    // A key reported down is pressed in the mask of its tick
    a_down_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.key_event == EV_DOWN)
            |-> o_out_data.pressed_mask[o_out_data.key_id])
        else $error("down event with key not pressed");

    // A key reported up is released in the mask of its tick
    a_up_not_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.key_event == EV_UP)
            |-> !o_out_data.pressed_mask[o_out_data.key_id])
        else $error("up event with key still pressed");

    // Events of one tick follow each other without a gap
    a_tick_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_of_tick) |=> o_out_valid)
        else $error("gap inside a tick's events");

endmodule
